// File: sv/slab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_pkg
// Shared constants, command/status words and state codes of the slab
// object allocator.
// ----------------------------------------------------------------------------
package slab_pkg;

  localparam int SLAB_SLOTS  = 16;
  localparam int SLAB_W      = 4;
  localparam int SID_W       = 5;
  localparam int MAX_OBJECTS = 512;
  localparam int OBJ_W       = 9;
  localparam int IDX_W       = 10;
  localparam int PAGE_SHIFT  = 12;
  localparam int DIV_STEPS   = 12;
  localparam int CNT_W       = 4;

  localparam logic [SID_W-1:0] NIL_SLAB  = SID_W'(SLAB_SLOTS);
  localparam logic [IDX_W-1:0] CHAIN_END = IDX_W'(MAX_OBJECTS);

  typedef enum logic [1:0] {
    LIST_FREE,
    LIST_PARTIAL,
    LIST_FULL
  } list_t;

  typedef enum logic [1:0] {
    CFG_OBJECT_SIZE,
    CFG_OBJECTS_PER_SLAB,
    CFG_DATA_OFFSET,
    CFG_REGION_BASE
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DECODE,
    OP_DIV,
    OP_SEL_HEAD,
    OP_REMOVE,
    OP_PUSH_HEAD,
    OP_GROW,
    OP_FILL,
    OP_READ,
    OP_MUL,
    OP_OUT_ALLOC,
    OP_OUT_ERR,
    OP_OUT_ZERO,
    OP_FREE_WR
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_A_REMF,
    ST_A_PUSHP,
    ST_A_FILL,
    ST_A_LINK,
    ST_A_READ,
    ST_A_MUL,
    ST_A_OUT,
    ST_A_REMP,
    ST_A_PUSHF,
    ST_F_DIV,
    ST_F_CHK,
    ST_F_MV1,
    ST_F_MV2,
    ST_F_MV3,
    ST_F_MV4
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
    list_t  lst;
  } dp_cmd_t;

  typedef struct packed {
    logic kind;
    logic partial_empty;
    logic free_empty;
    logic slots_full;
    logic fill_last;
    logic div_last;
    logic free_ok;
    logic chain_full;
    logic was_full;
    logic now_empty;
  } dp_stat_t;

endpackage

// File: sv/slab_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_dp
// Allocator datapath: configuration, slab lists, per-slab counters, chain
// memory, address divider and result word.
// ----------------------------------------------------------------------------
module slab_dp
  import slab_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_cmd_t                cmd,
  output dp_stat_t               stat,
  input  logic                   in_kind,
  input  logic [31:0]            in_free_address,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data,
  output logic                   out_strobe,
  output logic [31:0]            out_object_address,
  output logic [SLAB_W-1:0]      out_slab_number,
  output logic [OBJ_W-1:0]       out_object_index,
  output logic                   out_status
);

  logic [8:0]  object_size_r;
  logic [9:0]  objects_per_slab_r;
  logic [11:0] data_offset_r;
  logic [31:0] region_base_r;

  logic [SID_W-1:0]  head_r [3];
  logic [SID_W-1:0]  grown_r;

  logic [IDX_W-1:0]  ffi_r  [SLAB_SLOTS];
  logic [IDX_W-1:0]  used_r [SLAB_SLOTS];
  logic [SID_W-1:0]  nxt_r  [SLAB_SLOTS];
  logic [SID_W-1:0]  prv_r  [SLAB_SLOTS];

  logic [IDX_W-1:0]  chain_mem [SLAB_SLOTS*MAX_OBJECTS];
  logic [IDX_W-1:0]  chain_q_r;

  logic                  kind_r;
  logic [31:0]           addr_r;
  logic [SLAB_W-1:0]     s_r;
  logic [IDX_W-1:0]      idx_r;
  logic [IDX_W-1:0]      fi_r;
  logic [PAGE_SHIFT-1:0] quo_r;
  logic [8:0]            rem_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  valid_r;
  logic [31:0]           page_r;
  logic [18:0]           prod_r;
  logic                  rd_oob_r;
  logic                  chain_full_r;
  logic                  was_full_r;
  logic                  now_empty_r;
  logic                  out_strobe_r;
  logic [31:0]           out_addr_r;
  logic [SLAB_W-1:0]     out_slab_r;
  logic [OBJ_W-1:0]      out_idx_r;
  logic                  out_status_r;

  logic [IDX_W-1:0]  n_eff;
  logic [8:0]        size_eff;
  logic [SID_W-1:0]  sel_head;
  logic [SID_W-1:0]  cur_prev;
  logic [SID_W-1:0]  cur_next;
  logic [SID_W-1:0]  s_id;
  logic [SLAB_W-1:0] grow_slab;
  logic [IDX_W-1:0]  fill_next;
  logic [IDX_W-1:0]  new_ffi;
  logic [31:0]       off;
  logic [9:0]        trial;
  logic              trial_ge;
  logic              mem_we;
  logic [SLAB_W+OBJ_W-1:0] mem_waddr;
  logic [SLAB_W+OBJ_W-1:0] mem_raddr;
  logic [IDX_W-1:0]  mem_wdata;

  always_comb begin
    if (objects_per_slab_r == '0) begin
      n_eff = IDX_W'(1);
    end else if (objects_per_slab_r > CHAIN_END) begin
      n_eff = CHAIN_END;
    end else begin
      n_eff = objects_per_slab_r;
    end
    size_eff  = (object_size_r == '0) ? 9'd1 : object_size_r;
    sel_head  = head_r[cmd.lst];
    cur_prev  = prv_r[s_r];
    cur_next  = nxt_r[s_r];
    s_id      = {1'b0, s_r};
    grow_slab = grown_r[SLAB_W-1:0];
    fill_next = fi_r + 1'b1;
    new_ffi   = rd_oob_r ? CHAIN_END : chain_q_r;
    off       = addr_r - region_base_r;
    trial     = {rem_r, quo_r[PAGE_SHIFT-1]};
    trial_ge  = trial >= {1'b0, size_eff};
    mem_we    = (cmd.op == OP_FILL) || (cmd.op == OP_FREE_WR);
    if (cmd.op == OP_FILL) begin
      mem_waddr = {s_r, fi_r[OBJ_W-1:0]};
      mem_wdata = (fill_next < n_eff) ? fill_next : CHAIN_END;
    end else begin
      mem_waddr = {s_r, quo_r[OBJ_W-1:0]};
      mem_wdata = ffi_r[s_r];
    end
    mem_raddr = {s_r, ffi_r[s_r][OBJ_W-1:0]};
  end

  assign stat.kind          = kind_r;
  assign stat.partial_empty = head_r[LIST_PARTIAL][SID_W-1];
  assign stat.free_empty    = head_r[LIST_FREE][SID_W-1];
  assign stat.slots_full    = (grown_r == NIL_SLAB);
  assign stat.fill_last     = (fill_next == n_eff);
  assign stat.div_last      = (cnt_r == CNT_W'(DIV_STEPS - 1));
  assign stat.free_ok       = valid_r && ({2'b0, quo_r} < {4'b0, n_eff})
                              && (used_r[s_r] != '0);
  assign stat.chain_full    = chain_full_r;
  assign stat.was_full      = was_full_r;
  assign stat.now_empty     = now_empty_r;

  // chain memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      chain_mem[mem_waddr] <= mem_wdata;
    end
    chain_q_r <= chain_mem[mem_raddr];
  end

  // per-slab tables
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_REMOVE: begin
        if (!cur_prev[SID_W-1]) nxt_r[cur_prev[SLAB_W-1:0]] <= cur_next;
        if (!cur_next[SID_W-1]) prv_r[cur_next[SLAB_W-1:0]] <= cur_prev;
      end
      OP_PUSH_HEAD: begin
        prv_r[s_r] <= NIL_SLAB;
        nxt_r[s_r] <= sel_head;
        if (!sel_head[SID_W-1]) prv_r[sel_head[SLAB_W-1:0]] <= s_id;
      end
      OP_GROW: begin
        ffi_r[grow_slab]  <= '0;
        used_r[grow_slab] <= '0;
      end
      OP_READ: used_r[s_r] <= used_r[s_r] + 1'b1;
      OP_MUL: ffi_r[s_r] <= new_ffi;
      OP_FREE_WR: begin
        ffi_r[s_r]  <= quo_r[IDX_W-1:0];
        used_r[s_r] <= used_r[s_r] - 1'b1;
      end
      default: ;
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < 3; l++) begin
        head_r[l] <= NIL_SLAB;
      end
      grown_r            <= '0;
      out_strobe_r       <= 1'b0;
      object_size_r      <= 9'd8;
      objects_per_slab_r <= 10'd256;
      data_offset_r      <= 12'd2048;
      region_base_r      <= '0;
    end else begin
      out_strobe_r <= (cmd.op == OP_OUT_ALLOC) || (cmd.op == OP_OUT_ERR)
                      || (cmd.op == OP_OUT_ZERO) || (cmd.op == OP_FREE_WR);
      case (cmd.op)
        OP_REMOVE: begin
          if (cur_prev[SID_W-1]) head_r[cmd.lst] <= cur_next;
        end
        OP_PUSH_HEAD: begin
          head_r[cmd.lst] <= s_id;
        end
        OP_GROW: grown_r <= grown_r + 1'b1;
        default: ;
      endcase
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_OBJECT_SIZE:      object_size_r      <= cfg_data[8:0];
          CFG_OBJECTS_PER_SLAB: objects_per_slab_r <= cfg_data[9:0];
          CFG_DATA_OFFSET:      data_offset_r      <= cfg_data[11:0];
          CFG_REGION_BASE:      region_base_r      <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // request working registers and result word
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        kind_r <= in_kind;
        addr_r <= in_free_address;
      end
      OP_DECODE: begin
        s_r     <= off[PAGE_SHIFT+SLAB_W-1:PAGE_SHIFT];
        valid_r <= (off[31:PAGE_SHIFT+SLAB_W] == '0)
                   && ({1'b0, off[PAGE_SHIFT+SLAB_W-1:PAGE_SHIFT]} < grown_r)
                   && (off[PAGE_SHIFT-1:0] >= data_offset_r);
        quo_r   <= off[PAGE_SHIFT-1:0] - data_offset_r;
        rem_r   <= '0;
        cnt_r   <= '0;
      end
      OP_DIV: begin
        // restoring divide, one quotient bit a cycle
        rem_r <= trial_ge ? 9'(trial - {1'b0, size_eff}) : trial[8:0];
        quo_r <= {quo_r[PAGE_SHIFT-2:0], trial_ge};
        cnt_r <= cnt_r + 1'b1;
      end
      OP_SEL_HEAD: s_r <= sel_head[SLAB_W-1:0];
      OP_GROW: begin
        s_r  <= grow_slab;
        fi_r <= '0;
      end
      OP_FILL: fi_r <= fill_next;
      OP_READ: begin
        idx_r    <= ffi_r[s_r];
        rd_oob_r <= ffi_r[s_r][IDX_W-1];
        page_r   <= region_base_r + 32'({s_r, data_offset_r});
      end
      OP_MUL: begin
        prod_r       <= idx_r * size_eff;
        chain_full_r <= (new_ffi == CHAIN_END);
      end
      OP_OUT_ALLOC: begin
        out_addr_r   <= page_r + 32'(prod_r);
        out_slab_r   <= s_r;
        out_idx_r    <= idx_r[OBJ_W-1:0];
        out_status_r <= 1'b0;
      end
      OP_OUT_ERR: begin
        out_addr_r   <= '0;
        out_slab_r   <= '0;
        out_idx_r    <= '0;
        out_status_r <= 1'b1;
      end
      OP_OUT_ZERO: begin
        out_addr_r   <= '0;
        out_slab_r   <= '0;
        out_idx_r    <= '0;
        out_status_r <= 1'b0;
      end
      OP_FREE_WR: begin
        was_full_r   <= (used_r[s_r] == n_eff);
        now_empty_r  <= (used_r[s_r] == IDX_W'(1));
        out_addr_r   <= '0;
        out_slab_r   <= s_r;
        out_idx_r    <= quo_r[OBJ_W-1:0];
        out_status_r <= 1'b0;
      end
      default: ;
    endcase
  end

  assign out_strobe         = out_strobe_r;
  assign out_object_address = out_addr_r;
  assign out_slab_number    = out_slab_r;
  assign out_object_index   = out_idx_r;
  assign out_status         = out_status_r;

  a_grown_bound: assert property (@(posedge clk) disable iff (!rst_n)
    grown_r <= NIL_SLAB)
    else $error("slot count beyond region");

  a_serve_partial_head: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_READ |-> !head_r[LIST_PARTIAL][SID_W-1]
                          && head_r[LIST_PARTIAL][SLAB_W-1:0] == s_r)
    else $error("alloc not served from partial head");

  a_grow_free_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_GROW |-> head_r[LIST_FREE][SID_W-1]
                          && head_r[LIST_PARTIAL][SID_W-1])
    else $error("slab grown while a list still had room");

  a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |=> !out_strobe_r)
    else $error("two result words back to back");

endmodule

// File: sv/slab_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_ctrl
// Allocator sequencer: steps the datapath through one alloc or free
// request at a time.
// ----------------------------------------------------------------------------
module slab_ctrl
  import slab_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    cmd.lst   = LIST_FREE;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (stat.kind) begin
          cmd.op    = OP_DECODE;
          state_nxt = ST_F_DIV;
        end else if (!stat.partial_empty) begin
          cmd.op    = OP_SEL_HEAD;
          cmd.lst   = LIST_PARTIAL;
          state_nxt = ST_A_READ;
        end else if (!stat.free_empty) begin
          cmd.op    = OP_SEL_HEAD;
          cmd.lst   = LIST_FREE;
          state_nxt = ST_A_REMF;
        end else if (stat.slots_full) begin
          cmd.op    = OP_OUT_ERR;
          state_nxt = ST_IDLE;
        end else begin
          cmd.op    = OP_GROW;
          state_nxt = ST_A_FILL;
        end
      end
      ST_A_REMF: begin
        cmd.op    = OP_REMOVE;
        cmd.lst   = LIST_FREE;
        state_nxt = ST_A_PUSHP;
      end
      ST_A_PUSHP: begin
        cmd.op    = OP_PUSH_HEAD;
        cmd.lst   = LIST_PARTIAL;
        state_nxt = ST_A_READ;
      end
      ST_A_FILL: begin
        // link the new slab's chain, one entry a cycle
        cmd.op = OP_FILL;
        if (stat.fill_last) state_nxt = ST_A_LINK;
      end
      ST_A_LINK: begin
        cmd.op    = OP_PUSH_HEAD;
        cmd.lst   = LIST_PARTIAL;
        state_nxt = ST_A_READ;
      end
      ST_A_READ: begin
        cmd.op    = OP_READ;
        state_nxt = ST_A_MUL;
      end
      ST_A_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = ST_A_OUT;
      end
      ST_A_OUT: begin
        cmd.op    = OP_OUT_ALLOC;
        state_nxt = stat.chain_full ? ST_A_REMP : ST_IDLE;
      end
      ST_A_REMP: begin
        cmd.op    = OP_REMOVE;
        cmd.lst   = LIST_PARTIAL;
        state_nxt = ST_A_PUSHF;
      end
      ST_A_PUSHF: begin
        cmd.op    = OP_PUSH_HEAD;
        cmd.lst   = LIST_FULL;
        state_nxt = ST_IDLE;
      end
      ST_F_DIV: begin
        cmd.op = OP_DIV;
        if (stat.div_last) state_nxt = ST_F_CHK;
      end
      ST_F_CHK: begin
        if (stat.free_ok) begin
          cmd.op    = OP_FREE_WR;
          state_nxt = ST_F_MV1;
        end else begin
          cmd.op    = OP_OUT_ZERO;
          state_nxt = ST_IDLE;
        end
      end
      ST_F_MV1: begin
        if (stat.was_full) begin
          cmd.op    = OP_REMOVE;
          cmd.lst   = LIST_FULL;
          state_nxt = ST_F_MV2;
        end else if (stat.now_empty) begin
          cmd.op    = OP_REMOVE;
          cmd.lst   = LIST_PARTIAL;
          state_nxt = ST_F_MV4;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_F_MV2: begin
        cmd.op    = OP_PUSH_HEAD;
        cmd.lst   = LIST_PARTIAL;
        state_nxt = stat.now_empty ? ST_F_MV3 : ST_IDLE;
      end
      ST_F_MV3: begin
        cmd.op    = OP_REMOVE;
        cmd.lst   = LIST_PARTIAL;
        state_nxt = ST_F_MV4;
      end
      ST_F_MV4: begin
        cmd.op    = OP_PUSH_HEAD;
        cmd.lst   = LIST_FREE;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> state_r == ST_DISPATCH)
    else $error("accepted request not dispatched");

  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_F_CHK |-> $past(state_r, DIV_STEPS) == ST_F_DIV)
    else $error("divide cut short");

  a_fill_to_link: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_A_FILL && stat.fill_last |=> state_r == ST_A_LINK)
    else $error("chain fill did not finish into link");

endmodule

// File: sv/slab_object_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_object_allocator
// Fixed-size object allocator over sixteen page-sized slab slots.
// ----------------------------------------------------------------------------
// One request at a time: start is taken while busy is low, and each request
// gives exactly one result word, shown for one cycle with out_strobe, which
// the receiver must take. Growing a new slab links its chain entry by entry,
// the chain fill going through the single chain memory write port. A slab
// that fills up keeps busy high after the result while it moves to the full
// list. A free recovers the object index with a bit-serial divide, and may
// keep busy high after its result for list moves. No clearing pass runs
// after reset.
module slab_object_allocator
  import slab_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_kind,
  input  logic [31:0]       in_free_address,
  output logic              out_strobe,
  output logic [31:0]       out_object_address,
  output logic [SLAB_W-1:0] out_slab_number,
  output logic [OBJ_W-1:0]  out_object_index,
  output logic              out_status,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  slab_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  slab_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_kind            (in_kind),
    .in_free_address    (in_free_address),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_strobe         (out_strobe),
    .out_object_address (out_object_address),
    .out_slab_number    (out_slab_number),
    .out_object_index   (out_object_index),
    .out_status         (out_status)
  );

endmodule

// File: tb/slab_object_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_object_allocator_test
// Drives alloc and free requests through the allocator under several
// register settings and random sender gaps. A scoreboard keeps its own copy
// of the slab lists, free chains and in-use counts, predicts every result
// word and compares it field by field.
// ----------------------------------------------------------------------------
module slab_object_allocator_test;
  import slab_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [31:0]       addr;
    logic [SLAB_W-1:0] slab;
    logic [OBJ_W-1:0]  index;
    logic              status;
  } alloc_word_t;

  typedef struct {
    int slab;
    int index;
  } obj_ref_t;

  class slab_ledger;
    logic [IDX_W-1:0] chain [SLAB_SLOTS*MAX_OBJECTS];
    logic [IDX_W-1:0] first_free [SLAB_SLOTS];
    logic [IDX_W-1:0] in_use [SLAB_SLOTS];
    logic [SID_W-1:0] nxt [SLAB_SLOTS];
    logic [SID_W-1:0] prv [SLAB_SLOTS];
    logic [SID_W-1:0] head [3];
    logic [SID_W-1:0] tail [3];
    int               grown;
    logic [8:0]       obj_size;
    logic [9:0]       per_slab;
    logic [11:0]      data_off;
    logic [31:0]      base;
    alloc_word_t      awaited [$];
    obj_ref_t         live [$];
    int               mismatches;

    function new();
      foreach (chain[i]) chain[i] = '0;
      for (int s = 0; s < SLAB_SLOTS; s++) begin
        first_free[s] = '0;
        in_use[s] = '0;
        nxt[s] = '0;
        prv[s] = '0;
      end
      for (int l = 0; l < 3; l++) begin
        head[l] = NIL_SLAB;
        tail[l] = NIL_SLAB;
      end
      grown = 0;
      obj_size = 9'd8;
      per_slab = 10'd256;
      data_off = 12'd2048;
      base = '0;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] v);
      case (idx)
        CFG_OBJECT_SIZE:      obj_size = v[8:0];
        CFG_OBJECTS_PER_SLAB: per_slab = v[9:0];
        CFG_DATA_OFFSET:      data_off = v[11:0];
        CFG_REGION_BASE:      base = v;
        default: ;
      endcase
    endfunction

    function int count();
      if (per_slab == 0) return 1;
      if (per_slab > MAX_OBJECTS) return MAX_OBJECTS;
      return per_slab;
    endfunction

    function int stride();
      return (obj_size == 0) ? 1 : obj_size;
    endfunction

    function logic [31:0] addr_of(int s, int i);
      return base + (32'(s) << PAGE_SHIFT) + 32'(data_off) + 32'(i) * 32'(stride());
    endfunction

    function logic [IDX_W-1:0] chain_at(int s, int i);
      if (s >= SLAB_SLOTS || i >= MAX_OBJECTS) return CHAIN_END;
      return chain[s*MAX_OBJECTS + i];
    endfunction

    function void chain_set(int s, int i, logic [IDX_W-1:0] v);
      if (s < SLAB_SLOTS && i < MAX_OBJECTS) chain[s*MAX_OBJECTS + i] = v;
    endfunction

    function void unlink(list_t l, int s);
      logic [SID_W-1:0] p, n;
      if (s >= SLAB_SLOTS) return;
      p = prv[s];
      n = nxt[s];
      if (p < NIL_SLAB) nxt[p] = n; else head[l] = n;
      if (n < NIL_SLAB) prv[n] = p; else tail[l] = p;
      nxt[s] = NIL_SLAB;
      prv[s] = NIL_SLAB;
    endfunction

    function void push_front(list_t l, int s);
      logic [SID_W-1:0] h;
      h = head[l];
      if (s >= SLAB_SLOTS) return;
      prv[s] = NIL_SLAB;
      nxt[s] = h;
      if (h < NIL_SLAB) prv[h] = SID_W'(s); else tail[l] = SID_W'(s);
      head[l] = SID_W'(s);
    endfunction

    function void push_back(list_t l, int s);
      logic [SID_W-1:0] t;
      t = tail[l];
      if (s >= SLAB_SLOTS) return;
      nxt[s] = NIL_SLAB;
      prv[s] = t;
      if (t < NIL_SLAB) nxt[t] = SID_W'(s); else head[l] = SID_W'(s);
      tail[l] = SID_W'(s);
    endfunction

    function void promote_free();
      int s;
      if (head[LIST_PARTIAL] < NIL_SLAB) return;
      s = head[LIST_FREE];
      if (s >= SLAB_SLOTS) return;
      unlink(LIST_FREE, s);
      push_front(LIST_PARTIAL, s);
    endfunction

    function void forget(int s, int i);
      foreach (live[k])
        if (live[k].slab == s && live[k].index == i) begin
          live.delete(k);
          return;
        end
    endfunction

    // works out the word for one accepted request and updates the slab state
    function void note_request(logic kind, logic [31:0] fa);
      alloc_word_t w;
      int n, s, i, idx;
      logic [31:0] off;
      logic [11:0] in_page;
      obj_ref_t o;
      n = count();
      w = '0;
      if (kind == 1'b0) begin
        promote_free();
        if (head[LIST_PARTIAL] >= NIL_SLAB) begin
          if (grown >= SLAB_SLOTS) begin
            w.status = 1'b1;
            awaited.push_back(w);
            return;
          end
          s = grown++;
          for (i = 0; i + 1 < n; i++) chain_set(s, i, IDX_W'(i + 1));
          chain_set(s, n - 1, CHAIN_END);
          first_free[s] = '0;
          in_use[s] = '0;
          push_back(LIST_FREE, s);
          promote_free();
        end
        s = head[LIST_PARTIAL];
        idx = first_free[s];
        in_use[s] = in_use[s] + 1'b1;
        w.addr = addr_of(s, idx);
        w.slab = SLAB_W'(s);
        w.index = OBJ_W'(idx);
        first_free[s] = chain_at(s, idx);
        if (first_free[s] == CHAIN_END) begin
          unlink(LIST_PARTIAL, s);
          push_front(LIST_FULL, s);
        end
        o.slab = s;
        o.index = idx;
        live.push_back(o);
      end else begin
        off = fa - base;
        in_page = off[11:0];
        s = int'(off >> PAGE_SHIFT);
        if (s < grown && s < SLAB_SLOTS && in_page >= data_off) begin
          idx = int'(in_page - data_off) / stride();
          if (idx < n && in_use[s] != 0) begin
            chain_set(s, idx, first_free[s]);
            first_free[s] = IDX_W'(idx);
            if (in_use[s] == n) begin
              unlink(LIST_FULL, s);
              push_front(LIST_PARTIAL, s);
            end
            in_use[s] = in_use[s] - 1'b1;
            if (in_use[s] == 0) begin
              unlink(LIST_PARTIAL, s);
              push_front(LIST_FREE, s);
            end
            w.slab = SLAB_W'(s);
            w.index = OBJ_W'(idx);
            forget(s, idx);
          end
        end
      end
      awaited.push_back(w);
    endfunction

    function void check_result(alloc_word_t got);
      alloc_word_t exp;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: addr %h slab %0d index %0d status %0d",
                   got.addr, got.slab, got.index, got.status);
        return;
      end
      exp = awaited.pop_front();
      if (got.addr !== exp.addr || got.slab !== exp.slab ||
          got.index !== exp.index || got.status !== exp.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word mismatch: exp addr %h slab %0d index %0d status %0d, got addr %h slab %0d index %0d status %0d",
                   exp.addr, exp.slab, exp.index, exp.status,
                   got.addr, got.slab, got.index, got.status);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_kind = 1'b0;
  logic [31:0]       in_free_address = '0;
  logic              out_strobe;
  logic [31:0]       out_object_address;
  logic [SLAB_W-1:0] out_slab_number;
  logic [OBJ_W-1:0]  out_object_index;
  logic              out_status;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [31:0]       cfg_data = '0;

  slab_ledger ledger = new();
  int         cycles = 0;
  int         idle_pct = 0;

  slab_object_allocator dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("slab_object_allocator verification failed");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_strobe)
      ledger.check_result({out_object_address, out_slab_number, out_object_index, out_status});

  task automatic send_req(logic kind, logic [31:0] fa);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_free_address <= fa;
    do @(posedge clk); while (busy);
    ledger.note_request(kind, fa);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (ledger.awaited.size() != 0 || busy) @(posedge clk);
    // a slab that fills up keeps the block going after its word
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    ledger.set_reg(idx, v);
  endtask

  task automatic random_item();
    int r, k;
    logic [31:0] a;
    r = $urandom_range(99);
    if (r < 55) begin
      send_req(1'b0, $urandom);
    end else if (r < 88 && ledger.live.size() != 0) begin
      k = $urandom_range(ledger.live.size() - 1);
      send_req(1'b1, ledger.addr_of(ledger.live[k].slab, ledger.live[k].index));
    end else begin
      case ($urandom_range(2))
        0: a = $urandom;
        1: a = ledger.base + $urandom_range(SLAB_SLOTS * (1 << PAGE_SHIFT) - 1);
        default: begin
          a = ledger.addr_of($urandom_range(SLAB_SLOTS - 1),
                             $urandom_range(ledger.count()));
          a = a + $urandom_range(3) - 1;
        end
      endcase
      send_req(1'b1, a);
    end
  endtask

  logic [31:0] size_set [5] = '{256, 1, 0, 7, 100};
  logic [31:0] count_set [5] = '{1023, 300, 37, 3, 0};
  logic [31:0] offset_set [5] = '{0, 4095, 17, 1000, 2048};
  logic [31:0] base_set [5] = '{32'hFFFF_F000, 32'h1234_5678, 32'h0008_0000, 0, 0};

  initial begin
    int done;
    base_set[3] = $urandom;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default settings: 8-byte objects at 2048 in each page
    send_req(1'b0, 32'h0);
    send_req(1'b0, 32'hFFFF_FFFF);
    send_req(1'b0, 32'h0);
    send_req(1'b1, 32'd2056);
    send_req(1'b0, 32'h0);
    send_req(1'b1, 32'd2049);
    send_req(1'b1, 32'd2056);
    send_req(1'b1, 32'd2064);
    send_req(1'b1, 32'd2064);
    send_req(1'b1, 32'h0);
    send_req(1'b1, 32'h0000_5800);
    send_req(1'b1, 32'hFFFF_FFFF);
    send_req(1'b1, 32'd4096);
    send_req(1'b0, 32'h0);
    send_req(1'b0, 32'h0);
    settle();

    done = 0;
    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_OBJECT_SIZE, size_set[p]);
      write_reg(CFG_OBJECTS_PER_SLAB, count_set[p]);
      write_reg(CFG_DATA_OFFSET, offset_set[p]);
      write_reg(CFG_REGION_BASE, base_set[p]);
      for (int i = 0; i < 240; i++) begin
        idle_pct = (done < 400) ? 14 : (done < 800) ? 53 : 0;
        random_item();
        done++;
      end
      settle();
    end

    if (ledger.mismatches == 0 && ledger.awaited.size() == 0) begin
      $display("slab_object_allocator verification clean");
    end else begin
      $display("slab_object_allocator verification failed");
    end
    $finish;
  end

endmodule
